>>> design/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the pwm tone sequencer
// Operation codes, sequencer states, divider status and tone constants.
// ----------------------------------------------------------------------------
package pts_pkg;

    // default number of tone entries in the table
    localparam int TONE_DEPTH_DEF = 64;

    // timer base divide: prescale = round(BASE_CLOCK_DIV / freq) - 1
    localparam int BASE_CLOCK_DIV = 840000;

    // compare value while a tone sounds, out of a period of 100
    localparam logic [4:0] TONE_DUTY = 5'd25;

    // divider widths: numerator 2*base + freq, divisor 2*freq
    localparam int DIV_NUM_W = 21;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // operation codes carried in tuser
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_START   = 3'd2;
    localparam logic [2:0] OP_ENABLE  = 3'd3;
    localparam logic [2:0] OP_DISABLE = 3'd4;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } pts_state_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } pts_div_stat_t;

endpackage
`default_nettype wire

>>> design/pts_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_divider: iterative restoring divider
// One quotient bit per cycle; done pulses for one cycle after the last bit.
// ----------------------------------------------------------------------------
module pts_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [pts_pkg::DIV_NUM_W-1:0]   numer,
    input  wire logic [pts_pkg::DIV_DEN_W-1:0]   denom,
    output pts_pkg::pts_div_stat_t               stat,
    output logic      [pts_pkg::DIV_NUM_W-1:0]   quot
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [pts_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pts_pkg::DIV_NUM_W-1:0]   num_reg, num_next;
    logic [pts_pkg::DIV_DEN_W-1:0]   den_reg, den_next;
    logic [pts_pkg::DIV_DEN_W-1:0]   rem_reg, rem_next;
    logic [pts_pkg::DIV_DEN_W:0]     rem_shift;
    logic                            q_bit;

    // one restoring step: shift in the next numerator bit and try subtract
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[pts_pkg::DIV_NUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pts_pkg::DIV_CNT_W'(pts_pkg::DIV_NUM_W);
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[pts_pkg::DIV_NUM_W-2:0], q_bit};
            if (q_bit)
            begin
                rem_next = pts_pkg::DIV_DEN_W'(rem_shift - {1'b0, den_reg});
            end
            else
            begin
                rem_next = rem_shift[pts_pkg::DIV_DEN_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pts_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = num_reg;

endmodule
`default_nettype wire

>>> design/pwm_tone_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_tone_sequencer: tone sequencer for a pwm buzzer
// Plays a table of tones (frequency, duration) under millisecond tick items.
// ----------------------------------------------------------------------------
// One result item follows every input item. Each item passes from the idle
// state to the finish state and then into the output register; a tick that
// starts a sounding tone also passes through the read and divide states, where
// the restoring divider produces one prescaler quotient bit per cycle over 21
// bits. The input side is not ready while an item is at work; a finished
// result waits in the output register while the next item is accepted. The
// tone table is a single-port memory with a registered read, and entries never written read as undefined.
module pwm_tone_sequencer #(
    parameter int TONE_DEPTH = pts_pkg::TONE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tuser: op[2:0]
    input  wire logic [2:0]  s_tuser,
    // tdata: tone_addr[5:0], tone_freq[21:6], tone_ticks[37:22], play_count[44:38]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: duty_compare[4:0], prescale[24:5], playing[25], enabled_now[26]
    output logic [31:0]      m_tdata
);

    localparam int AW = (TONE_DEPTH > 1) ? $clog2(TONE_DEPTH) : 1;

    // input fields
    logic [5:0]  tone_addr;
    logic [15:0] tone_freq;
    logic [15:0] tone_ticks;
    logic [6:0]  play_count;
    logic        in_acc;

    assign tone_addr  = s_tdata[5:0];
    assign tone_freq  = s_tdata[21:6];
    assign tone_ticks = s_tdata[37:22];
    assign play_count = s_tdata[44:38];
    assign in_acc     = s_tvalid && s_tready;

    // sequencer state
    pts_pkg::pts_state_t state_reg, state_next;
    logic [6:0]  seq_len_reg, seq_len_next;
    logic [6:0]  seq_pos_reg, seq_pos_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic        active_reg, active_next;
    logic        enable_reg, enable_next;
    logic [4:0]  compare_reg, compare_next;
    logic [19:0] prescale_reg, prescale_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        div_start;

    // tone table
    logic [31:0]   tone_mem [TONE_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [31:0]   wr_addr_ext;
    logic [31:0]   rd_addr_ext;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;
    logic          wr_en;
    logic          rd_en;

    // divider
    logic [pts_pkg::DIV_NUM_W-1:0] div_numer;
    logic [pts_pkg::DIV_DEN_W-1:0] div_denom;
    logic [pts_pkg::DIV_NUM_W-1:0] div_quot;
    pts_pkg::pts_div_stat_t        div_stat;

    assign wr_addr_ext = 32'(tone_addr);
    assign rd_addr_ext = 32'(seq_pos_reg);
    assign wr_idx      = wr_addr_ext[AW-1:0];
    assign rd_idx      = rd_addr_ext[AW-1:0];
    assign wr_en       = in_acc && (s_tuser == pts_pkg::OP_WRITE)
                         && (wr_addr_ext < 32'(TONE_DEPTH));
    assign rd_en       = in_acc && (s_tuser == pts_pkg::OP_TICK);

    // table write and registered read at the current position
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tone_mem[wr_idx] <= {tone_ticks, tone_freq};
        end
        if (rd_en)
        begin
            rd_data_reg <= tone_mem[rd_idx];
        end
    end

    // divider operands from the loaded entry: (2*base + f) / (2*f)
    assign div_numer = pts_pkg::DIV_NUM_W'(2 * pts_pkg::BASE_CLOCK_DIV)
                       + pts_pkg::DIV_NUM_W'(rd_data_reg[15:0]);
    assign div_denom = {rd_data_reg[15:0], 1'b0};

    pts_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // next state and datapath updates
    always_comb
    begin
        state_next      = state_reg;
        seq_len_next    = seq_len_reg;
        seq_pos_next    = seq_pos_reg;
        ticks_left_next = ticks_left_reg;
        active_next     = active_reg;
        enable_next     = enable_reg;
        compare_next    = compare_reg;
        prescale_next   = prescale_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        div_start       = 1'b0;
        s_tready        = (state_reg == pts_pkg::ST_IDLE);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = pts_pkg::ST_FINISH;
                    case (s_tuser)
                        pts_pkg::OP_TICK:
                        begin
                            if (enable_reg && active_reg)
                            begin
                                if (ticks_left_reg != 16'd0)
                                begin
                                    ticks_left_next = ticks_left_reg - 16'd1;
                                end
                                else if (seq_pos_reg >= seq_len_reg)
                                begin
                                    active_next  = 1'b0;
                                    seq_len_next = '0;
                                    compare_next = '0;
                                end
                                else
                                begin
                                    state_next = pts_pkg::ST_READ;
                                end
                            end
                        end
                        pts_pkg::OP_START:
                        begin
                            if (enable_reg)
                            begin
                                if (32'(play_count) > 32'(TONE_DEPTH))
                                begin
                                    seq_len_next = 7'(TONE_DEPTH);
                                end
                                else
                                begin
                                    seq_len_next = play_count;
                                end
                                seq_pos_next    = '0;
                                ticks_left_next = 16'd1;
                                active_next     = 1'b1;
                                compare_next    = '0;
                            end
                        end
                        pts_pkg::OP_ENABLE:
                        begin
                            enable_next = 1'b1;
                        end
                        pts_pkg::OP_DISABLE:
                        begin
                            enable_next  = 1'b0;
                            compare_next = '0;
                        end
                        default:
                        begin
                            // table writes are handled at the memory
                        end
                    endcase
                end
            end
            pts_pkg::ST_READ:
            begin
                // load the entry's duration and start its prescaler if sounding
                ticks_left_next = rd_data_reg[31:16];
                seq_pos_next    = seq_pos_reg + 7'd1;
                if (rd_data_reg[15:0] == 16'd0)
                begin
                    compare_next = '0;
                    state_next   = pts_pkg::ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = pts_pkg::ST_DIV;
                end
            end
            pts_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    prescale_next = div_quot[19:0] - 20'd1;
                    compare_next  = pts_pkg::TONE_DUTY;
                    state_next    = pts_pkg::ST_FINISH;
                end
            end
            pts_pkg::ST_FINISH:
            begin
                // hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, enable_reg, active_reg,
                                     prescale_reg, compare_reg};
                    state_next    = pts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg    <= '0;
            seq_pos_reg    <= '0;
            ticks_left_reg <= 16'd1;
            active_reg     <= 1'b0;
            enable_reg     <= 1'b1;
            compare_reg    <= '0;
            prescale_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            seq_len_reg    <= seq_len_next;
            seq_pos_reg    <= seq_pos_next;
            ticks_left_reg <= ticks_left_next;
            active_reg     <= active_next;
            enable_reg     <= enable_next;
            compare_reg    <= compare_next;
            prescale_reg   <= prescale_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // compare is either silent or the tone duty
    a_compare_code: assert property (@(posedge clk) disable iff (!rst_n)
        (compare_reg == 5'd0) || (compare_reg == pts_pkg::TONE_DUTY))
        else $error("compare holds an illegal value");

    // a disabled buzzer stays silent
    a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !enable_reg |-> (compare_reg == 5'd0))
        else $error("compare nonzero while disabled");

    // an idle sequencer has no length left
    a_idle_length: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (seq_len_reg == 7'd0))
        else $error("sequence length kept after play stopped");

    // divider results only arrive while waiting for them
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == pts_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    // a divide is started only from the table read step and runs in the divide state
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_stat.busy && (state_reg == pts_pkg::ST_DIV))
        else $error("divider start not followed by divide");
`endif

endmodule
`default_nettype wire

>>> bench/pwm_tone_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_tone_sequencer_tb: self-checking bench of the pwm tone sequencer
// Drives tick, write, start, enable and disable items on the input stream and
// compares every status item on the output stream with a cycle-free model of
// the sequencer kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module pwm_tone_sequencer_tb;

    localparam int DEPTH = pts_pkg::TONE_DEPTH_DEF;

    // input item fields, last field in the lowest bits
    typedef struct packed {
        logic [6:0]  play_count;
        logic [15:0] tone_ticks;
        logic [15:0] tone_freq;
        logic [5:0]  tone_addr;
    } tone_item_t;

    // status item fields, last field in the lowest bits
    typedef struct packed {
        logic [4:0]  fill;
        logic        enabled_now;
        logic        playing;
        logic [19:0] prescale;
        logic [4:0]  duty_compare;
    } tone_status_t;

    // model of the sequencer and the queue of status items it predicts
    class tone_scoreboard;
        logic [31:0]  tone_mem [DEPTH];
        int unsigned  seq_len;
        int unsigned  seq_pos;
        logic [15:0]  ticks_left;
        bit           active;
        bit           buzzer_on;
        logic [4:0]   compare_val;
        logic [19:0]  prescale_val;
        tone_status_t status_q [$];
        int           errors;

        function new();
            foreach (tone_mem[i]) tone_mem[i] = '0;
            seq_len      = 0;
            seq_pos      = 0;
            ticks_left   = 16'd1;
            active       = 1'b0;
            buzzer_on    = 1'b1;
            compare_val  = '0;
            prescale_val = '0;
            errors       = 0;
        endfunction

        // apply one accepted item and queue the status it must produce
        function void note_item(logic [2:0] op, tone_item_t item);
            logic [31:0]  entry;
            int unsigned  freq;
            int unsigned  quot;
            tone_status_t status;
            case (op)
                pts_pkg::OP_TICK:
                begin
                    if (buzzer_on && active)
                    begin
                        if (ticks_left != 0)
                            ticks_left = ticks_left - 16'd1;
                        else if (seq_pos >= seq_len || seq_pos >= DEPTH)
                        begin
                            active      = 1'b0;
                            seq_len     = 0;
                            compare_val = '0;
                        end
                        else
                        begin
                            entry      = tone_mem[seq_pos];
                            seq_pos    = seq_pos + 1;
                            ticks_left = entry[31:16];
                            freq       = {16'd0, entry[15:0]};
                            if (freq == 0)
                                compare_val = '0;
                            else
                            begin
                                // base divide by freq, rounded half up, minus one
                                quot         = (2 * pts_pkg::BASE_CLOCK_DIV + freq)
                                               / (2 * freq);
                                prescale_val = 20'(quot - 1);
                                compare_val  = pts_pkg::TONE_DUTY;
                            end
                        end
                    end
                end
                pts_pkg::OP_WRITE:
                begin
                    if (item.tone_addr < DEPTH)
                        tone_mem[item.tone_addr] = {item.tone_ticks, item.tone_freq};
                end
                pts_pkg::OP_START:
                begin
                    if (buzzer_on)
                    begin
                        seq_len     = (item.play_count > DEPTH) ? DEPTH
                                                                : 32'(item.play_count);
                        seq_pos     = 0;
                        ticks_left  = 16'd1;
                        active      = 1'b1;
                        compare_val = '0;
                    end
                end
                pts_pkg::OP_ENABLE:
                    buzzer_on = 1'b1;
                pts_pkg::OP_DISABLE:
                begin
                    buzzer_on   = 1'b0;
                    compare_val = '0;
                end
                default: ;
            endcase
            status              = '0;
            status.duty_compare = compare_val;
            status.prescale     = prescale_val;
            status.playing      = active;
            status.enabled_now  = buzzer_on;
            status_q.push_back(status);
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one received status item with the oldest prediction
        function void check_status(logic [31:0] raw);
            tone_status_t exp_s;
            tone_status_t act_s;
            act_s = raw;
            if (status_q.size() == 0)
            begin
                $display("%0t: status expected none actual %h", $time, raw);
                errors++;
            end
            else
            begin
                exp_s = status_q.pop_front();
                check_field("duty_compare", exp_s.duty_compare, act_s.duty_compare);
                check_field("prescale", exp_s.prescale, act_s.prescale);
                check_field("playing", exp_s.playing, act_s.playing);
                check_field("enabled_now", exp_s.enabled_now, act_s.enabled_now);
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    tone_scoreboard board = new();
    int src_idle_pct;
    int snk_stall_pct;
    int hold_left;

    pwm_tone_sequencer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic tone_item_t tone_fields(logic [5:0] addr, logic [15:0] freq,
                                               logic [15:0] ticks, logic [6:0] count);
        tone_item_t item;
        item.tone_addr  = addr;
        item.tone_freq  = freq;
        item.tone_ticks = ticks;
        item.play_count = count;
        return item;
    endfunction

    // offer one item after a random gap and wait for it to be taken
    task automatic send_item(logic [2:0] op, tone_item_t item);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, item};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(op, item);
    endtask

    // table write with mostly short durations and some rests
    task automatic send_tone_entry(logic [5:0] addr);
        tone_item_t item;
        int unsigned pick;
        item.tone_addr  = addr;
        item.play_count = 7'($urandom);
        pick = $urandom_range(99);
        if (pick < 75)
            item.tone_ticks = 16'($urandom_range(4));
        else if (pick < 95)
            item.tone_ticks = 16'($urandom_range(40));
        else
            item.tone_ticks = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 20)
            item.tone_freq = '0;
        else if (pick < 30)
            item.tone_freq = 16'($urandom_range(16, 1));
        else
            item.tone_freq = 16'($urandom);
        send_item(pts_pkg::OP_WRITE, item);
    endtask

    // one random item, weighted toward ticks so sequences play through
    task automatic send_random_op();
        tone_item_t item;
        int unsigned pick;
        int unsigned sub;
        item.tone_addr  = 6'($urandom);
        item.tone_freq  = 16'($urandom);
        item.tone_ticks = 16'($urandom);
        item.play_count = 7'($urandom);
        pick = $urandom_range(99);
        if (pick < 58)
            send_item(pts_pkg::OP_TICK, item);
        else if (pick < 72)
            send_tone_entry(6'($urandom));
        else if (pick < 81)
        begin
            sub = $urandom_range(99);
            if (sub < 50)
                item.play_count = 7'($urandom_range(6));
            else if (sub < 85)
                item.play_count = 7'($urandom_range(DEPTH));
            else
                item.play_count = 7'($urandom_range(127, DEPTH + 1));
            send_item(pts_pkg::OP_START, item);
        end
        else if (pick < 89)
            send_item(pts_pkg::OP_ENABLE, item);
        else if (pick < 95)
            send_item(pts_pkg::OP_DISABLE, item);
        else
            send_item(pts_pkg::OP_DISABLE + 3'($urandom_range(3, 1)), item);
    endtask

    // run limit
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: check each taken item, then pick the next ready
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_status(m_tdata);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // stimulus
    initial
    begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_left     = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= pts_pkg::OP_TICK;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick while idle, then an empty sequence that stops on its second tick
        send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));
        send_item(pts_pkg::OP_START, tone_fields(0, 0, 0, 0));
        send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));
        send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));

        // lowest tone, half-up rounding, rest, top tone, all-ones entry
        send_item(pts_pkg::OP_WRITE, tone_fields(0, 16'd1, 16'd1, 0));
        send_item(pts_pkg::OP_WRITE, tone_fields(1, 16'd48000, 16'd0, 0));
        send_item(pts_pkg::OP_WRITE, tone_fields(2, 16'd0, 16'd0, 0));
        send_item(pts_pkg::OP_WRITE, tone_fields(3, 16'hFFFF, 16'd2, 0));
        send_item(pts_pkg::OP_WRITE, tone_fields(6'h3F, 16'hFFFF, 16'hFFFF, 7'h7F));

        // start a sequence of four entries and play through tone, tone, rest
        send_item(pts_pkg::OP_START, tone_fields(6'h3F, 16'hFFFF, 16'hFFFF, 7'd4));
        repeat (5) send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));

        // disable freezes play and a start while disabled is ignored
        send_item(pts_pkg::OP_DISABLE, tone_fields(0, 0, 0, 0));
        send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));
        send_item(pts_pkg::OP_START, tone_fields(0, 0, 0, 7'd1));
        send_item(pts_pkg::OP_ENABLE, tone_fields(0, 0, 0, 0));
        send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));

        // unused op codes change nothing
        send_item(pts_pkg::OP_DISABLE + 3'd1,
                  tone_fields(6'h3F, 16'hFFFF, 16'hFFFF, 7'h7F));
        send_item(pts_pkg::OP_DISABLE + 3'd3, tone_fields(0, 0, 0, 0));

        // count the last tone down and run past the end
        repeat (3) send_item(pts_pkg::OP_TICK, tone_fields(0, 0, 0, 0));

        // random phases with different idle patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            s_tvalid <= 1'b0;
            while (board.pending() != 0)
                @(posedge clk);
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 73;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 73;
                end
                default:
                begin
                    src_idle_pct  = 25;
                    snk_stall_pct = 25;
                end
            endcase
            if (phase == 0)
            begin
                // fill the whole table so any count may be played
                for (int a = 0; a < DEPTH; a++)
                    send_tone_entry(6'(a));
                // long output hold-off while items keep coming
                hold_left = 300;
            end
            repeat (455) send_random_op();
        end
        s_tvalid <= 1'b0;

        // drain and let the block settle
        while (board.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
        begin
            if (board.pending() != 0)
                $display("%0t: status expected %0d more actual none", $time, board.pending());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
